>>> rtl/core/iirl_pkg.sv
`timescale 1ns / 1ps

package iirl_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned COUNT_W = 5;

  // Command codes on the input channel
  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Broadcast control from the list controller to every cell
  typedef struct packed {
    logic                     ins;   // open a slot at the selected position
    logic                     rem;   // close the slot at the selected position
    logic signed [WORD_W-1:0] word;  // word written into the opened slot
  } cell_ctl_t;

endpackage

>>> rtl/core/iirl_cell.sv
`timescale 1ns / 1ps

module iirl_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned PW  = 5
) (
  input  logic                              clk,
  input  iirl_pkg::cell_ctl_t               ctl,
  input  logic [PW-1:0]                     sel_pos,
  input  logic signed [iirl_pkg::WORD_W-1:0] lo_word,
  input  logic signed [iirl_pkg::WORD_W-1:0] hi_word,
  output logic signed [iirl_pkg::WORD_W-1:0] entry
);
  import iirl_pkg::*;

  localparam logic [PW-1:0] MY_IDX = PW'(IDX);

  logic signed [WORD_W-1:0] entry_r;
  logic signed [WORD_W-1:0] entry_nxt;

  // Shift up, load, shift down or hold, depending on where this cell sits
  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins && (MY_IDX > sel_pos)) begin
      entry_nxt = lo_word;
    end else if (ctl.ins && (MY_IDX == sel_pos)) begin
      entry_nxt = ctl.word;
    end else if (ctl.rem && (MY_IDX >= sel_pos)) begin
      entry_nxt = hi_word;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

>>> rtl/core/indexed_insert_remove_list_unit.sv
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY signed 32-bit words, held in a row of cells,
// one word per cell. Append, insert at a position, remove at a position and
// read at a position act on the whole row: every cell shifts up, shifts down,
// loads or holds in the same clock edge, so a new command is accepted every
// cycle while the result register can be emptied. Each command yields one
// result with the read word (zero unless a successful read), a status (ok,
// position out of range, list full), the count after the command and an
// empty flag. Refused commands leave the list unchanged. The result register
// decouples the two channels; a result is valid the cycle after acceptance.

module indexed_insert_remove_list_unit #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  iirl_pkg::cmd_t                     in_cmd,
  input  logic [iirl_pkg::POS_W-1:0]         in_position,
  input  logic signed [iirl_pkg::WORD_W-1:0] in_word_in,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [iirl_pkg::WORD_W-1:0] out_word_out,
  output iirl_pkg::status_t                  out_status,
  output logic [iirl_pkg::COUNT_W-1:0]       out_count,
  output logic                               out_empty_res
);
  import iirl_pkg::*;

  localparam int unsigned FW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = (FW > POS_W) ? FW : POS_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic [FW-1:0]            fill_r;
  logic [FW-1:0]            fill_nxt;
  logic                     out_valid_r;
  logic                     out_valid_nxt;
  logic signed [WORD_W-1:0] word_out_r;
  status_t                  status_r;
  logic [COUNT_W-1:0]       count_r;
  logic                     empty_r;

  logic                     in_acc;
  logic [CW-1:0]            pos_c;
  logic [CW-1:0]            fill_c;
  status_t                  status_c;
  logic signed [WORD_W-1:0] rd_word;
  logic [FW-1:0]            sel_pos;
  cell_ctl_t                ctl;

  logic signed [WORD_W-1:0] entry_w [CAPACITY];
  logic signed [WORD_W-1:0] lo_w    [CAPACITY];
  logic signed [WORD_W-1:0] hi_w    [CAPACITY];

  // Handshake: take an item unless a result is waiting and held off
  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  assign pos_c  = CW'(in_position);
  assign fill_c = CW'(fill_r);

  // Command check against the current fill
  always_comb begin
    status_c = ST_OK;
    case (in_cmd)
      CMD_APPEND: begin
        if (fill_c >= CAP_C) status_c = ST_FULL;
      end
      CMD_INSERT: begin
        if (pos_c > fill_c) status_c = ST_RANGE;
        else if (fill_c >= CAP_C) status_c = ST_FULL;
      end
      default: begin
        if (pos_c >= fill_c) status_c = ST_RANGE;
      end
    endcase
  end

  // Broadcast control to the cells
  always_comb begin
    ctl.ins  = in_acc && (status_c == ST_OK) &&
               ((in_cmd == CMD_APPEND) || (in_cmd == CMD_INSERT));
    ctl.rem  = in_acc && (status_c == ST_OK) && (in_cmd == CMD_REMOVE);
    ctl.word = in_word_in;
    sel_pos  = (in_cmd == CMD_APPEND) ? fill_r : FW'(in_position);
  end

  // Fill count update
  always_comb begin
    fill_nxt = fill_r;
    if (ctl.ins) fill_nxt = fill_r + FW'(1);
    else if (ctl.rem) fill_nxt = fill_r - FW'(1);
  end

  // Read port over the cell outputs
  always_comb begin
    rd_word = '0;
    if ((in_cmd == CMD_READ) && (status_c == ST_OK)) rd_word = entry_w[pos_c[IW-1:0]];
  end

  // Row of cells, each linked to its neighbors
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign lo_w[g] = '0;
    end else begin : g_mid_lo
      assign lo_w[g] = entry_w[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign hi_w[g] = '0;
    end else begin : g_mid_hi
      assign hi_w[g] = entry_w[g+1];
    end

    iirl_cell #(
      .IDX (g),
      .PW  (FW)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .sel_pos (sel_pos),
      .lo_word (lo_w[g]),
      .hi_word (hi_w[g]),
      .entry   (entry_w[g])
    );
  end

  // Result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (in_acc) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload, loaded with each accepted item
  always_ff @(posedge clk) begin
    if (in_acc) begin
      word_out_r <= rd_word;
      status_r   <= status_c;
      count_r    <= COUNT_W'(fill_nxt);
      empty_r    <= (fill_nxt == '0);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_word_out  = word_out_r;
  assign out_status    = status_r;
  assign out_count     = count_r;
  assign out_empty_res = empty_r;

endmodule

>>> sim/tb_indexed_insert_remove_list_unit.sv
`timescale 1ns / 1ps

module tb_indexed_insert_remove_list_unit;
  import iirl_pkg::*;

  localparam int unsigned CAPACITY   = 16;
  localparam int unsigned RAND_ITEMS = 1750;
  localparam int unsigned HOLD_AT    = 400;  // accepted items before the long hold-off
  localparam int unsigned HOLD_LEN   = 150;  // cycles of the long hold-off

  // One command item and one result item
  typedef struct {
    cmd_t                     cmd;
    logic [POS_W-1:0]         pos;
    logic signed [WORD_W-1:0] word;
  } list_cmd_t;

  typedef struct {
    logic signed [WORD_W-1:0] word;
    status_t                  status;
    logic [COUNT_W-1:0]       count;
    logic                     empty;
  } list_result_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  cmd_t                     in_cmd = CMD_APPEND;
  logic [POS_W-1:0]         in_position = '0;
  logic signed [WORD_W-1:0] in_word_in = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [WORD_W-1:0] out_word_out;
  status_t                  out_status;
  logic [COUNT_W-1:0]       out_count;
  logic                     out_empty_res;

  list_cmd_t    pending_cmds[$];
  list_result_t expected_results[$];

  // Shadow list used to predict results
  logic signed [WORD_W-1:0] shadow_words[CAPACITY];
  int unsigned              shadow_fill = 0;

  // Count tracked while generating stimulus, to aim positions
  int unsigned gen_fill = 0;

  int unsigned error_count = 0;
  int unsigned accepted_items = 0;
  logic        in_took = 1'b0;

  list_cmd_t    drive_cmd;
  list_result_t next_result;
  list_result_t oldest_result;
  int unsigned  burst_left = 8;
  int unsigned  gap_left = 0;
  int unsigned  stall_mode = 0;
  int unsigned  stall_phase = 0;
  int unsigned  hold_left = 0;
  bit           hold_done = 1'b0;

  indexed_insert_remove_list_unit #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_position  (in_position),
    .in_word_in   (in_word_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_word_out (out_word_out),
    .out_status   (out_status),
    .out_count    (out_count),
    .out_empty_res(out_empty_res)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Queue an item and track the count it leaves behind
  function automatic void push_cmd(cmd_t cmd, logic [POS_W-1:0] pos,
                                   logic signed [WORD_W-1:0] word);
    list_cmd_t it;
    it.cmd  = cmd;
    it.pos  = pos;
    it.word = word;
    pending_cmds.push_back(it);
    case (cmd)
      CMD_APPEND: if (gen_fill < CAPACITY) gen_fill++;
      CMD_INSERT: if (pos <= gen_fill && gen_fill < CAPACITY) gen_fill++;
      CMD_REMOVE: if (pos < gen_fill) gen_fill--;
      default: ;
    endcase
  endfunction

  // Position aimed mostly at legal slots, sometimes anywhere
  function automatic logic [POS_W-1:0] pick_pos(cmd_t cmd);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return POS_W'($urandom_range(CAPACITY + 1, 31));
    if (r < 15) return POS_W'($urandom_range(0, CAPACITY));
    if (r < 25) begin
      case ($urandom_range(0, 2))
        0: return '0;
        1: return POS_W'(gen_fill);
        default: return POS_W'((gen_fill == 0) ? 0 : gen_fill - 1);
      endcase
    end
    if (cmd == CMD_INSERT) return POS_W'($urandom_range(0, gen_fill));
    if (gen_fill == 0) return POS_W'($urandom_range(0, CAPACITY));
    return POS_W'($urandom_range(0, gen_fill - 1));
  endfunction

  function automatic logic signed [WORD_W-1:0] pick_word();
    if ($urandom_range(0, 99) < 12) begin
      case ($urandom_range(0, 4))
        0: return '0;
        1: return -1;
        2: return 32'sh7FFF_FFFF;
        3: return 32'sh8000_0000;
        default: return 1;
      endcase
    end
    return $urandom;
  endfunction

  // Open a slot at pos, shifting later words up
  task automatic open_slot(int unsigned pos, logic signed [WORD_W-1:0] word);
    for (int unsigned i = shadow_fill; i > pos; i--)
      shadow_words[i] = shadow_words[i - 1];
    shadow_words[pos] = word;
    shadow_fill++;
  endtask

  // Apply one command to the shadow list and produce its result
  task automatic apply_list_cmd(input list_cmd_t it, output list_result_t r);
    r.word   = '0;
    r.status = ST_OK;
    case (it.cmd)
      CMD_APPEND: begin
        if (shadow_fill >= CAPACITY) r.status = ST_FULL;
        else open_slot(shadow_fill, it.word);
      end
      CMD_INSERT: begin
        if (it.pos > shadow_fill) r.status = ST_RANGE;
        else if (shadow_fill >= CAPACITY) r.status = ST_FULL;
        else open_slot(it.pos, it.word);
      end
      CMD_REMOVE: begin
        if (it.pos >= shadow_fill) begin
          r.status = ST_RANGE;
        end else begin
          for (int unsigned i = it.pos; i + 1 < shadow_fill; i++)
            shadow_words[i] = shadow_words[i + 1];
          shadow_fill--;
        end
      end
      default: begin
        if (it.pos >= shadow_fill) r.status = ST_RANGE;
        else r.word = shadow_words[it.pos];
      end
    endcase
    r.count = COUNT_W'(shadow_fill);
    r.empty = (shadow_fill == 0);
  endtask

  // Driver: bursts of items with random gaps
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (gap_left > 0 || pending_cmds.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_valid <= 1'b0;
      end else begin
        drive_cmd = pending_cmds.pop_front();
        in_valid    <= 1'b1;
        in_cmd      <= drive_cmd.cmd;
        in_position <= drive_cmd.pos;
        in_word_in  <= drive_cmd.word;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // Receiver stall: random modes, plus one long hold-off
  always @(negedge clk) begin
    logic stall_next;
    stall_phase++;
    if (stall_phase % 50 == 0) stall_mode = $urandom_range(0, 3);
    if (!hold_done && accepted_items >= HOLD_AT) begin
      hold_left = HOLD_LEN;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      stall_next = 1'b1;
    end else begin
      case (stall_mode)
        0: stall_next = 1'b0;
        1: stall_next = ($urandom_range(0, 3) == 0);
        2: stall_next = ($urandom_range(0, 3) != 0);
        default: stall_next = (stall_phase % 8) >= 5;
      endcase
    end
    out_stall <= stall_next;
  end

  // Input side: predict each accepted item
  always @(posedge clk) begin
    in_took <= rst_n && in_valid === 1'b1 && in_stall === 1'b0;
    if (rst_n && in_valid === 1'b1 && in_stall === 1'b0) begin
      apply_list_cmd('{cmd: in_cmd, pos: in_position, word: in_word_in}, next_result);
      expected_results.push_back(next_result);
      accepted_items++;
    end
  end

  // Output side: compare each accepted result with the oldest expected one
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_results.size() == 0) begin
        $error("result item with nothing expected");
        error_count++;
      end else begin
        oldest_result = expected_results.pop_front();
        if (out_word_out !== oldest_result.word) begin
          $error("word_out: expected %0d, got %0d", oldest_result.word, out_word_out);
          error_count++;
        end
        if (out_status !== oldest_result.status) begin
          $error("status: expected %0d, got %0d", oldest_result.status, out_status);
          error_count++;
        end
        if (out_count !== oldest_result.count) begin
          $error("count: expected %0d, got %0d", oldest_result.count, out_count);
          error_count++;
        end
        if (out_empty_res !== oldest_result.empty) begin
          $error("empty_res: expected %0d, got %0d", oldest_result.empty, out_empty_res);
          error_count++;
        end
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int unsigned r;
    bit          grow;
    cmd_t        cmd;

    // empty list: read, remove and insert past the end are refused
    push_cmd(CMD_READ, 5'd0, 32'sd0);
    push_cmd(CMD_REMOVE, 5'd0, 32'sd0);
    push_cmd(CMD_INSERT, 5'd1, 32'sd5);
    // insert at the count acts as append
    push_cmd(CMD_INSERT, 5'd0, 32'sh7FFF_FFFF);
    push_cmd(CMD_APPEND, 5'd31, 32'sh8000_0000);
    push_cmd(CMD_INSERT, 5'd0, -1);
    push_cmd(CMD_INSERT, 5'd3, 32'sd0);
    push_cmd(CMD_READ, 5'd1, 32'sd0);
    push_cmd(CMD_READ, 5'd3, 32'sd0);
    push_cmd(CMD_REMOVE, 5'd1, 32'sd0);
    push_cmd(CMD_READ, 5'd3, 32'sd0);
    // fill up, then hit the full cases
    repeat (CAPACITY - 3) push_cmd(CMD_APPEND, 5'd0, $urandom);
    push_cmd(CMD_APPEND, 5'd0, 32'sd7);
    push_cmd(CMD_INSERT, 5'd5, 32'sd7);
    push_cmd(CMD_INSERT, 5'd16, 32'sd7);
    push_cmd(CMD_INSERT, 5'd31, 32'sd7);
    push_cmd(CMD_READ, 5'd15, 32'sd0);
    push_cmd(CMD_READ, 5'd16, 32'sd0);
    push_cmd(CMD_REMOVE, 5'd15, 32'sd0);
    push_cmd(CMD_REMOVE, 5'd0, 32'sd0);
    push_cmd(CMD_READ, 5'd0, 32'sd0);

    // random part: drift between full and empty
    grow = 1'b1;
    repeat (RAND_ITEMS) begin
      if (gen_fill == CAPACITY && $urandom_range(0, 3) == 0) grow = 1'b0;
      if (gen_fill == 0 && $urandom_range(0, 3) == 0) grow = 1'b1;
      if ($urandom_range(0, 49) == 0) grow = !grow;
      r = $urandom_range(0, 99);
      if (grow)
        cmd = (r < 40) ? CMD_APPEND : (r < 70) ? CMD_INSERT : (r < 82) ? CMD_REMOVE : CMD_READ;
      else
        cmd = (r < 10) ? CMD_APPEND : (r < 22) ? CMD_INSERT : (r < 65) ? CMD_REMOVE : CMD_READ;
      push_cmd(cmd, (cmd == CMD_APPEND) ? POS_W'($urandom_range(0, 31)) : pick_pos(cmd),
               pick_word());
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() != 0 || in_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/iirl_pkg.sv
rtl/core/iirl_cell.sv
rtl/core/indexed_insert_remove_list_unit.sv
sim/tb_indexed_insert_remove_list_unit.sv
